FILE: rtl/core/rrt_pkg.sv
// Package for the tree extension step block: register indexes, function and
// status codes, word types and default sizes. No dependencies.
package rrt_pkg;
    localparam int TreeDepthDef = 1024;
    localparam int MapMaxWDef = 256;
    localparam int MapMaxHDef = 256;

    localparam logic [1:0] FUNC_MAP_WRITE = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_EXTEND = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_OUTSIDE = 2'd3;

    localparam logic [2:0] REG_STEP = 3'd0;
    localparam logic [2:0] REG_WIDTH = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_GOAL_X = 3'd3;
    localparam logic [2:0] REG_GOAL_Y = 3'd4;
    localparam logic [2:0] REG_THRESH = 3'd5;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] coord_x;
        logic [7:0] coord_y;
        logic       cell_free;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] nearest_index;
        logic [7:0] nearest_x;
        logic [7:0] nearest_y;
        logic [8:0] nearest_distance;
        logic [7:0] new_x;
        logic [7:0] new_y;
        logic       collided;
        logic       at_goal;
    } t_out_word;
endpackage

FILE: rtl/core/rrt_if.sv
// Valid/ready channel interface carrying one word of a given type.
// No dependencies; the word type is a parameter.
interface rrt_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/rrt_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module rrt_ram #(
    parameter int Width = 8,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: rtl/core/rrt_extend_step_top.sv
// Top level of the tree extension step block: map and point memories and the
// sequencer around one shared square-root unit. Depends on rrt_pkg, rrt_if, rrt_ram.
//
// One word is taken at a time. Map writes, appends and clears go from the
// decode state to the output state and back to ready once the result is taken.
// An extend reads the stored points one at a time and resolves each point's
// rounded distance with a shared bit-serial square root of 9 steps. Each cell
// checked along the step takes one map RAM read. A second square root follows
// for the goal test.
// The map size limits are fixed at 256 by 256 in the package.
// The memories need no clearing pass after reset.
module rrt_extend_step_top #(
    parameter int TREE_DEPTH = rrt_pkg::TreeDepthDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [8:0] i_cfg_data,
    rrt_if.sink        in_ch,
    rrt_if.source      out_ch
);
    import rrt_pkg::*;

    localparam int MAP_MAX_WIDTH = MapMaxWDef;
    localparam int MAP_MAX_HEIGHT = MapMaxHDef;
    localparam int PAW = (TREE_DEPTH > 1) ? $clog2(TREE_DEPTH) : 1;
    localparam int CW = $clog2(TREE_DEPTH + 1);
    localparam int XW = $clog2(MAP_MAX_WIDTH);
    localparam int YW = $clog2(MAP_MAX_HEIGHT);
    localparam int MAW = XW + YW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC = 4'd1;
    localparam logic [3:0] S_SREQ = 4'd2;
    localparam logic [3:0] S_SWAIT = 4'd3;
    localparam logic [3:0] S_SLOAD = 4'd4;
    localparam logic [3:0] S_SQRT = 4'd5;
    localparam logic [3:0] S_SCMP = 4'd6;
    localparam logic [3:0] S_NREQ = 4'd7;
    localparam logic [3:0] S_NWAIT = 4'd8;
    localparam logic [3:0] S_CSTEP = 4'd9;
    localparam logic [3:0] S_CWAIT = 4'd10;
    localparam logic [3:0] S_CCHK = 4'd11;
    localparam logic [3:0] S_GOAL = 4'd12;
    localparam logic [3:0] S_GDONE = 4'd13;
    localparam logic [3:0] S_OUT = 4'd14;

    logic [3:0] r_state;
    logic [7:0] r_step;
    logic [8:0] r_mw, r_mh;
    logic [7:0] r_gx, r_gy;
    logic [8:0] r_thr;
    logic [CW-1:0] r_count;
    t_in_word r_in;
    t_out_word r_out;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_best;
    logic [8:0] r_best_d;
    logic r_best_ok;
    logic [7:0] r_nx, r_ny;
    logic signed [1:0] r_ux, r_uy;
    logic signed [10:0] r_px, r_py;
    logic [7:0] r_k;
    logic [7:0] r_cx, r_cy;
    logic r_coll;

    // Shared square root: remainder/root over 9 result bits, then half-up rounding.
    logic [17:0] r_rad;
    logic [17:0] r_rad_full;
    logic [19:0] r_rem;
    logic [8:0] r_root;
    logic [3:0] r_sq_cnt;

    // Effective map size.
    logic [12:0] w_eff, h_eff;
    always_comb begin
        if (r_mw == 9'd0) w_eff = 13'd1;
        else if ({4'd0, r_mw} > 13'(MAP_MAX_WIDTH)) w_eff = 13'(MAP_MAX_WIDTH);
        else w_eff = {4'd0, r_mw};
        if (r_mh == 9'd0) h_eff = 13'd1;
        else if ({4'd0, r_mh} > 13'(MAP_MAX_HEIGHT)) h_eff = 13'(MAP_MAX_HEIGHT);
        else h_eff = {4'd0, r_mh};
    end
    logic w_inside;
    assign w_inside = ({5'd0, r_in.coord_x} < w_eff) && ({5'd0, r_in.coord_y} < h_eff);

    // Status of the word being decoded; a clear always succeeds.
    logic [1:0] w_dec_status;
    always_comb begin
        w_dec_status = ST_OK;
        if (r_in.func != FUNC_CLEAR) begin
            if (!w_inside) w_dec_status = ST_OUTSIDE;
            else if (r_in.func == FUNC_APPEND && r_count >= CW'(TREE_DEPTH))
                w_dec_status = ST_FULL;
            else if (r_in.func == FUNC_EXTEND && r_count == '0) w_dec_status = ST_EMPTY;
        end
    end

    // Point RAM shares one address between append writes and scan reads.
    logic w_pt_we;
    logic [PAW-1:0] w_pt_addr;
    logic [15:0] w_pt_rd;
    assign w_pt_we = (r_state == S_DEC) && (r_in.func == FUNC_APPEND) && w_inside
                     && (r_count < CW'(TREE_DEPTH));
    always_comb begin
        if (r_state == S_DEC) w_pt_addr = r_count[PAW-1:0];
        else if (r_state == S_NREQ) w_pt_addr = r_best[PAW-1:0];
        else w_pt_addr = r_idx[PAW-1:0];
    end
    rrt_ram #(.Width(16), .Depth(TREE_DEPTH)) u_pts (
        .i_clk(i_clk), .i_we(w_pt_we), .i_addr(w_pt_addr),
        .i_wdata({r_in.coord_x, r_in.coord_y}), .o_rdata(w_pt_rd)
    );

    // Map RAM.
    logic w_map_we;
    logic [MAW-1:0] w_map_addr;
    logic w_map_rd;
    assign w_map_we = (r_state == S_DEC) && (r_in.func == FUNC_MAP_WRITE) && w_inside;
    always_comb begin
        if (r_state == S_DEC) w_map_addr = {r_in.coord_y[YW-1:0], r_in.coord_x[XW-1:0]};
        else w_map_addr = {r_cy[YW-1:0], r_cx[XW-1:0]};
    end
    rrt_ram #(.Width(1), .Depth(MAP_MAX_WIDTH * MAP_MAX_HEIGHT)) u_map (
        .i_clk(i_clk), .i_we(w_map_we), .i_addr(w_map_addr),
        .i_wdata(r_in.cell_free), .o_rdata(w_map_rd)
    );

    // Differences to the sample, squared for the scan.
    logic signed [8:0] w_dx, w_dy;
    assign w_dx = $signed({1'b0, w_pt_rd[15:8]}) - $signed({1'b0, r_in.coord_x});
    assign w_dy = $signed({1'b0, w_pt_rd[7:0]}) - $signed({1'b0, r_in.coord_y});

    // Goal differences from the clamped point.
    logic signed [8:0] w_gdx, w_gdy;
    assign w_gdx = $signed({1'b0, r_gx}) - $signed({1'b0, r_cx});
    assign w_gdy = $signed({1'b0, r_gy}) - $signed({1'b0, r_cy});

    // One root step.
    logic [19:0] w_trial, w_rem_sh;
    assign w_rem_sh = {r_rem[17:0], r_rad[17:16]};
    assign w_trial = {9'd0, r_root, 2'b01};
    logic [8:0] w_rounded;
    assign w_rounded = (r_rad_full > ({9'd0, r_root} * {9'd0, r_root} + {9'd0, r_root}))
                       ? r_root + 9'd1 : r_root;

    // Unit direction of one axis: sign when 2*|d| >= distance.
    function automatic logic signed [1:0] unit_of(input logic signed [8:0] d,
                                                  input logic [8:0] mag);
        logic [8:0] a;
        a = d[8] ? 9'(-d) : 9'(d);
        if (mag == 9'd0 || {a, 1'b0} < {1'b0, mag}) return 2'sd0;
        return d[8] ? -2'sd1 : 2'sd1;
    endfunction

    function automatic logic [7:0] clampv(input logic signed [10:0] v, input logic [12:0] lim);
        logic signed [13:0] hi;
        hi = $signed({1'b0, lim}) - 14'sd1;
        if (v < 0) return 8'd0;
        if ($signed({{3{v[10]}}, v}) > hi) return hi[7:0];
        return v[7:0];
    endfunction

    // Direction from the nearest point, read from the point RAM, to the sample.
    logic signed [8:0] w_sdx, w_sdy;
    assign w_sdx = $signed({1'b0, r_in.coord_x}) - $signed({1'b0, w_pt_rd[15:8]});
    assign w_sdy = $signed({1'b0, r_in.coord_y}) - $signed({1'b0, w_pt_rd[7:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step <= 8'd1;
            r_mw <= 9'd256;
            r_mh <= 9'd256;
            r_gx <= 8'd0;
            r_gy <= 8'd0;
            r_thr <= 9'd0;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_STEP: r_step <= i_cfg_data[7:0];
                    REG_WIDTH: r_mw <= i_cfg_data;
                    REG_HEIGHT: r_mh <= i_cfg_data;
                    REG_GOAL_X: r_gx <= i_cfg_data[7:0];
                    REG_GOAL_Y: r_gy <= i_cfg_data[7:0];
                    REG_THRESH: r_thr <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_in <= in_ch.data;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_out <= {w_dec_status, {($bits(t_out_word) - 2){1'b0}}};
                    if (r_in.func == FUNC_EXTEND && w_dec_status == ST_OK) begin
                        r_idx <= '0;
                        r_best <= '0;
                        r_best_ok <= 1'b0;
                        r_state <= S_SREQ;
                    end else begin
                        r_state <= S_OUT;
                    end
                    if (r_in.func == FUNC_CLEAR) r_count <= '0;
                    else if (r_in.func == FUNC_APPEND && w_dec_status == ST_OK)
                        r_count <= r_count + CW'(1);
                end
                S_SREQ: r_state <= S_SWAIT;
                S_SWAIT: r_state <= S_SLOAD;
                S_SLOAD: begin
                    r_rad <= 18'(w_dx * w_dx) + 18'(w_dy * w_dy);
                    r_rad_full <= 18'(w_dx * w_dx) + 18'(w_dy * w_dy);
                    r_rem <= '0;
                    r_root <= '0;
                    r_sq_cnt <= 4'd9;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_sq_cnt == 4'd0) begin
                        r_state <= S_SCMP;
                    end else begin
                        r_rad <= {r_rad[15:0], 2'b00};
                        r_sq_cnt <= r_sq_cnt - 4'd1;
                        if (w_rem_sh >= w_trial) begin
                            r_rem <= w_rem_sh - w_trial;
                            r_root <= {r_root[7:0], 1'b1};
                        end else begin
                            r_rem <= w_rem_sh;
                            r_root <= {r_root[7:0], 1'b0};
                        end
                    end
                end
                S_SCMP: begin
                    if (!r_best_ok || w_rounded < r_best_d) begin
                        r_best_d <= w_rounded;
                        r_best <= r_idx;
                        r_best_ok <= 1'b1;
                    end
                    if (r_idx + CW'(1) >= r_count) begin
                        r_state <= S_NREQ;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                        r_state <= S_SREQ;
                    end
                end
                S_NREQ: r_state <= S_NWAIT;
                S_NWAIT: begin
                    r_nx <= w_pt_rd[15:8];
                    r_ny <= w_pt_rd[7:0];
                    r_ux <= unit_of(w_sdx, r_best_d);
                    r_uy <= unit_of(w_sdy, r_best_d);
                    r_px <= 11'({3'd0, w_pt_rd[15:8]});
                    r_py <= 11'({3'd0, w_pt_rd[7:0]});
                    r_cx <= clampv(11'({3'd0, w_pt_rd[15:8]}), w_eff);
                    r_cy <= clampv(11'({3'd0, w_pt_rd[7:0]}), h_eff);
                    r_k <= 8'd0;
                    r_coll <= 1'b0;
                    r_state <= S_CSTEP;
                end
                S_CSTEP: begin
                    if (r_k == r_step) begin
                        r_state <= S_GOAL;
                    end else begin
                        r_k <= r_k + 8'd1;
                        r_px <= r_px + 11'(r_ux);
                        r_py <= r_py + 11'(r_uy);
                        r_cx <= clampv(r_px + 11'(r_ux), w_eff);
                        r_cy <= clampv(r_py + 11'(r_uy), h_eff);
                        r_state <= S_CWAIT;
                    end
                end
                S_CWAIT: r_state <= S_CCHK;
                S_CCHK: begin
                    if (!w_map_rd) r_coll <= 1'b1;
                    r_state <= S_CSTEP;
                end
                S_GOAL: begin
                    r_rad <= 18'(w_gdx * w_gdx) + 18'(w_gdy * w_gdy);
                    r_rad_full <= 18'(w_gdx * w_gdx) + 18'(w_gdy * w_gdy);
                    r_rem <= '0;
                    r_root <= '0;
                    r_sq_cnt <= 4'd9;
                    r_state <= S_GDONE;
                end
                S_GDONE: begin
                    if (r_sq_cnt == 4'd0) begin
                        r_out.status <= ST_OK;
                        r_out.nearest_index <= 10'(r_best);
                        r_out.nearest_x <= r_nx;
                        r_out.nearest_y <= r_ny;
                        r_out.nearest_distance <= r_best_d;
                        r_out.new_x <= r_cx;
                        r_out.new_y <= r_cy;
                        r_out.collided <= r_coll;
                        r_out.at_goal <= (w_rounded < r_thr);
                        r_state <= S_OUT;
                    end else begin
                        r_rad <= {r_rad[15:0], 2'b00};
                        r_sq_cnt <= r_sq_cnt - 4'd1;
                        if (w_rem_sh >= w_trial) begin
                            r_rem <= w_rem_sh - w_trial;
                            r_root <= {r_root[7:0], 1'b1};
                        end else begin
                            r_rem <= w_rem_sh;
                            r_root <= {r_root[7:0], 1'b0};
                        end
                    end
                end
                S_OUT: if (out_ch.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign in_ch.ready = (r_state == S_IDLE);
    assign out_ch.valid = (r_state == S_OUT);
    assign out_ch.data = r_out;

    // The stored point count never exceeds the list depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TREE_DEPTH)) else $error("point count above depth");
    // A finished word is offered only after one was accepted and not while taking input.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ch.ready && out_ch.valid)) else $error("input and output both open");
    // A clear always empties the list.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC && r_in.func == FUNC_CLEAR) |=> (r_count == '0))
        else $error("clear left points");
    // A non-ok status never carries a nonzero nearest distance.
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && out_ch.data.status != ST_OK) |-> (out_ch.data.nearest_distance == 9'd0))
        else $error("stale result fields");
endmodule
